// ===== hdl/spc_pkg.sv =====
// Shared types, constants and register codes of the sampled PID controller.
`default_nettype none

package spc_pkg;

   // Configuration port geometry
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // Register indexes on the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GAIN_P        = 3'd0,
      REG_GAIN_I        = 3'd1,
      REG_GAIN_D        = 3'd2,
      REG_OUT_MIN       = 3'd3,
      REG_OUT_MAX       = 3'd4,
      REG_SAMPLE_PERIOD = 3'd5
   } reg_idx_type;

   // Register values after reset
   localparam logic [15:0] RST_GAIN_P        = 16'd256;
   localparam logic [15:0] RST_GAIN_I        = 16'd0;
   localparam logic [15:0] RST_GAIN_D        = 16'd0;
   localparam logic [15:0] RST_OUT_MIN       = 16'hFFA6;  // -90
   localparam logic [15:0] RST_OUT_MAX       = 16'd90;
   localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd75;

   // Datapath widths
   localparam int ACC_W  = 64;  // wraparound width of the PID sum
   localparam int CNT_W  = 6;   // step counter of the sequencer
   localparam int QUOT_W = 34;  // magnitude of gain_d times error change

   // Last step of each iterative phase
   localparam logic [CNT_W-1:0] LAST_MUL_D  = 6'd16;  // 17-bit gain magnitude
   localparam logic [CNT_W-1:0] LAST_MUL_16 = 6'd15;  // signed 16-bit gain
   localparam logic [CNT_W-1:0] LAST_MUL_DT = 6'd31;  // 32-bit elapsed time
   localparam logic [CNT_W-1:0] LAST_DIV    = 6'd33;  // 34 quotient bits

   // Live configuration
   typedef struct packed {
      logic signed [15:0] gain_p;
      logic signed [15:0] gain_i;
      logic signed [15:0] gain_d;
      logic signed [15:0] out_min;
      logic signed [15:0] out_max;
      logic        [15:0] sample_period;
   } cfg_type;

   // Sequencer states
   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_PREP  = 11'b000_0000_0010,
      S_MULD  = 11'b000_0000_0100,
      S_DIV   = 11'b000_0000_1000,
      S_DNEG  = 11'b000_0001_0000,
      S_MULP  = 11'b000_0010_0000,
      S_MULI1 = 11'b000_0100_0000,
      S_MULI2 = 11'b000_1000_0000,
      S_ROUND = 11'b001_0000_0000,
      S_CLAMP = 11'b010_0000_0000,
      S_DONE  = 11'b100_0000_0000
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/spc_regs.sv =====
// Configuration register file of the sampled PID controller.
`default_nettype none

module spc_regs (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [spc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [spc_pkg::CSR_DAT_W-1:0] csr_wdata,
   output spc_pkg::cfg_type                   cfg
);

   spc_pkg::cfg_type cfg_ff;
   spc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode a write; drop unknown indexes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            spc_pkg::REG_GAIN_P:        cfg_in.gain_p        = csr_wdata;
            spc_pkg::REG_GAIN_I:        cfg_in.gain_i        = csr_wdata;
            spc_pkg::REG_GAIN_D:        cfg_in.gain_d        = csr_wdata;
            spc_pkg::REG_OUT_MIN:       cfg_in.out_min       = csr_wdata;
            spc_pkg::REG_OUT_MAX:       cfg_in.out_max       = csr_wdata;
            spc_pkg::REG_SAMPLE_PERIOD: cfg_in.sample_period = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p        <= spc_pkg::RST_GAIN_P;
         cfg_ff.gain_i        <= spc_pkg::RST_GAIN_I;
         cfg_ff.gain_d        <= spc_pkg::RST_GAIN_D;
         cfg_ff.out_min       <= spc_pkg::RST_OUT_MIN;
         cfg_ff.out_max       <= spc_pkg::RST_OUT_MAX;
         cfg_ff.sample_period <= spc_pkg::RST_SAMPLE_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/spc_alu.sv =====
// Shared 64-bit add/subtract unit of the sampled PID controller.
`default_nettype none

module spc_alu (
   input  wire logic [spc_pkg::ACC_W-1:0] op_a,
   input  wire logic [spc_pkg::ACC_W-1:0] op_b,
   input  wire logic                      sub,
   output logic      [spc_pkg::ACC_W-1:0] result
);

   // Add or subtract modulo 2^64
   assign result = sub ? (op_a - op_b) : (op_a + op_b);

endmodule

`default_nettype wire

// ===== hdl/sampled_pid_controller.sv =====
// Top level of the sampled PID controller: sequencer, state and stream ports.
`default_nettype none

// Sampled PID controller. Each request carries a setpoint, a measurement, a
// millisecond time stamp and a restart flag, and yields exactly one response.
// When the elapsed time reaches sample_period the block computes
// P + D + I in 64-bit wraparound arithmetic with Q8.8 gains, divides by 256
// toward zero and clamps to [out_min, out_max]; otherwise it repeats the held
// drive value with updated = 0. A request is taken only while the sequencer is
// idle. The multiply, divide, sign-fix and rounding steps run through one
// 64-bit add/subtract unit. A computed update runs through setup, the
// derivative product, the restoring divide by elapsed time, sign fix, the
// proportional and first integral products, the product with elapsed time,
// rounding, clamping and handover; with zero elapsed time the divide is
// skipped. A held value or a restart goes from setup straight to handover.
// The next request is taken in the cycle after the response moves into the
// output register; while an earlier response still waits there for
// rsp_tready, the sequencer holds in its last step. Configuration writes are
// accepted in every cycle and must be issued while no request is in flight.
module sampled_pid_controller (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request: [15:0] target_value, [31:16] measured_value, [63:32] now_ms
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [63:0]                   req_tdata,
   input  wire logic                          req_tuser,  // [0] restart
   // response: [15:0] drive_out
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [15:0]                        rsp_tdata,
   output logic                               rsp_tuser,  // [0] updated
   // configuration writes
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [spc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [spc_pkg::CSR_DAT_W-1:0] csr_wdata
);

   localparam int W = spc_pkg::ACC_W;
   localparam int Q = spc_pkg::QUOT_W;

   spc_pkg::cfg_type   cfg;
   spc_pkg::state_type state_ff, state_in;

   // Captured request
   logic signed [15:0] tgt_ff, tgt_in;
   logic signed [15:0] meas_ff, meas_in;
   logic [31:0]        now_ff, now_in;
   logic               rst_ff, rst_in;

   // Controller state
   logic signed [16:0] prev_err_ff, prev_err_in;
   logic signed [31:0] err_sum_ff, err_sum_in;
   logic signed [15:0] held_ff, held_in;
   logic [31:0]        last_ms_ff, last_ms_in;

   // Working registers
   logic signed [16:0]    err_ff, err_in;
   logic [31:0]           dt_ff, dt_in;
   logic                  dneg_ff, dneg_in;
   logic [spc_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [W-1:0]          acc_ff, acc_in;
   logic [W-1:0]          tmp_ff, tmp_in;
   logic [W-1:0]          mcand_ff, mcand_in;
   logic [31:0]           mplier_ff, mplier_in;
   logic [31:0]           rem_ff, rem_in;

   // Result and output registers
   logic [15:0] res_drive_ff, res_drive_in;
   logic        res_upd_ff, res_upd_in;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_drive_ff, out_drive_in;
   logic        out_upd_ff, out_upd_in;

   // Shared unit operands
   logic [W-1:0] alu_a, alu_b, alu_y;
   logic         alu_sub;

   // Preparation logic
   logic signed [16:0] p_err;
   logic signed [32:0] p_sum_raw;
   logic signed [31:0] p_sum;
   logic signed [17:0] p_diff;
   logic [17:0]        p_diff_mag;
   logic [16:0]        p_gd_mag;
   logic [31:0]        p_dt;
   logic               p_upd;

   // Step helpers
   logic [spc_pkg::CNT_W-1:0] mul_last;
   logic                      mul_is_last;
   logic                      mul_sub;
   logic [W-1:0]              mul_addend;
   logic [32:0]               div_rs;
   logic                      div_q;
   logic signed [W-1:0]       fin_val;
   logic signed [W-1:0]       lo64, hi64;
   logic [15:0]               clamp_val;

   spc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spc_alu u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .sub    (alu_sub),
      .result (alu_y)
   );

   assign req_tready = (state_ff == spc_pkg::S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_drive_ff;
   assign rsp_tuser  = out_upd_ff;

   // Error, saturated sum, error change and elapsed time
   always_comb begin
      p_err      = {tgt_ff[15], tgt_ff} - {meas_ff[15], meas_ff};
      p_sum_raw  = {err_sum_ff[31], err_sum_ff} + {{16{p_err[16]}}, p_err};
      if (p_sum_raw[32] != p_sum_raw[31]) begin
         p_sum = p_sum_raw[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         p_sum = p_sum_raw[31:0];
      end
      p_diff     = {p_err[16], p_err} - {prev_err_ff[16], prev_err_ff};
      p_diff_mag = p_diff[17] ? (~p_diff + 18'd1) : p_diff;
      p_gd_mag   = cfg.gain_d[15] ? (~{cfg.gain_d[15], cfg.gain_d} + 17'd1)
                                  : {1'b0, cfg.gain_d};
      p_dt       = now_ff - last_ms_ff;
      p_upd      = (p_dt >= {16'd0, cfg.sample_period});
   end

   // Multiply step: add or subtract the shifted multiplicand per multiplier bit
   always_comb begin
      unique case (state_ff)
         spc_pkg::S_MULD:  mul_last = spc_pkg::LAST_MUL_D;
         spc_pkg::S_MULI2: mul_last = spc_pkg::LAST_MUL_DT;
         default:          mul_last = spc_pkg::LAST_MUL_16;
      endcase
      mul_is_last = (cnt_ff == mul_last);
      mul_sub     = mul_is_last &&
                    (state_ff == spc_pkg::S_MULP || state_ff == spc_pkg::S_MULI1);
      mul_addend  = mplier_ff[0] ? mcand_ff : '0;
   end

   // Divide step: shift in one dividend bit, trial subtract elapsed time
   assign div_rs = {rem_ff, tmp_ff[Q-1]};
   assign div_q  = ~alu_y[W-1];

   // Shared unit operand selection
   always_comb begin
      alu_a   = acc_ff;
      alu_b   = mul_addend;
      alu_sub = mul_sub;
      unique case (state_ff)
         spc_pkg::S_MULD, spc_pkg::S_MULI1: begin
            alu_a = tmp_ff;
         end
         spc_pkg::S_DIV: begin
            alu_a   = {{(W-33){1'b0}}, div_rs};
            alu_b   = {{(W-32){1'b0}}, dt_ff};
            alu_sub = 1'b1;
         end
         spc_pkg::S_DNEG: begin
            alu_a   = '0;
            alu_b   = {{(W-Q){1'b0}}, tmp_ff[Q-1:0]};
            alu_sub = dneg_ff;
         end
         spc_pkg::S_ROUND: begin
            alu_a   = {{8{acc_ff[W-1]}}, acc_ff[W-1:8]};
            alu_b   = {{(W-1){1'b0}}, (acc_ff[W-1] && (acc_ff[7:0] != 8'd0))};
            alu_sub = 1'b0;
         end
         default: begin
            alu_a = acc_ff;
         end
      endcase
   end

   // Clamp the rounded value to the limits
   always_comb begin
      fin_val = acc_ff;
      lo64    = {{(W-16){cfg.out_min[15]}}, cfg.out_min};
      hi64    = {{(W-16){cfg.out_max[15]}}, cfg.out_max};
      if (fin_val < lo64) begin
         clamp_val = cfg.out_min;
      end else if (fin_val > hi64) begin
         clamp_val = cfg.out_max;
      end else begin
         clamp_val = acc_ff[15:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      tgt_in       = tgt_ff;
      meas_in      = meas_ff;
      now_in       = now_ff;
      rst_in       = rst_ff;
      prev_err_in  = prev_err_ff;
      err_sum_in   = err_sum_ff;
      held_in      = held_ff;
      last_ms_in   = last_ms_ff;
      err_in       = err_ff;
      dt_in        = dt_ff;
      dneg_in      = dneg_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      tmp_in       = tmp_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      rem_in       = rem_ff;
      res_drive_in = res_drive_ff;
      res_upd_in   = res_upd_ff;
      out_valid_in = out_valid_ff;
      out_drive_in = out_drive_ff;
      out_upd_in   = out_upd_ff;

      // Drop the response once taken
      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         spc_pkg::S_IDLE: begin
            if (req_tvalid) begin
               tgt_in   = req_tdata[15:0];
               meas_in  = req_tdata[31:16];
               now_in   = req_tdata[63:32];
               rst_in   = req_tuser;
               state_in = spc_pkg::S_PREP;
            end
         end
         spc_pkg::S_PREP: begin
            if (rst_ff) begin
               prev_err_in  = '0;
               err_sum_in   = '0;
               held_in      = '0;
               last_ms_in   = now_ff;
               res_drive_in = '0;
               res_upd_in   = 1'b0;
               state_in     = spc_pkg::S_DONE;
            end else if (!p_upd) begin
               res_drive_in = held_ff;
               res_upd_in   = 1'b0;
               state_in     = spc_pkg::S_DONE;
            end else begin
               prev_err_in = p_err;
               err_sum_in  = p_sum;
               last_ms_in  = now_ff;
               err_in      = p_err;
               dt_in       = p_dt;
               dneg_in     = cfg.gain_d[15] ^ p_diff[17];
               tmp_in      = '0;
               mcand_in    = {{(W-18){1'b0}}, p_diff_mag};
               mplier_in   = {15'd0, p_gd_mag};
               cnt_in      = '0;
               state_in    = spc_pkg::S_MULD;
            end
         end
         spc_pkg::S_MULD: begin
            tmp_in    = alu_y;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 1'b1;
            if (mul_is_last) begin
               cnt_in = '0;
               rem_in = '0;
               if (dt_ff == 32'd0) begin
                  tmp_in   = '0;
                  state_in = spc_pkg::S_DNEG;
               end else begin
                  state_in = spc_pkg::S_DIV;
               end
            end
         end
         spc_pkg::S_DIV: begin
            rem_in = div_q ? alu_y[31:0] : div_rs[31:0];
            tmp_in = {tmp_ff[W-2:0], div_q};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == spc_pkg::LAST_DIV) begin
               state_in = spc_pkg::S_DNEG;
            end
         end
         spc_pkg::S_DNEG: begin
            acc_in    = alu_y;
            mcand_in  = {{(W-17){err_ff[16]}}, err_ff};
            mplier_in = {16'd0, cfg.gain_p};
            cnt_in    = '0;
            state_in  = spc_pkg::S_MULP;
         end
         spc_pkg::S_MULP: begin
            acc_in    = alu_y;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 1'b1;
            if (mul_is_last) begin
               tmp_in    = '0;
               mcand_in  = {{(W-32){err_sum_ff[31]}}, err_sum_ff};
               mplier_in = {16'd0, cfg.gain_i};
               cnt_in    = '0;
               state_in  = spc_pkg::S_MULI1;
            end
         end
         spc_pkg::S_MULI1: begin
            tmp_in    = alu_y;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 1'b1;
            if (mul_is_last) begin
               mcand_in  = alu_y;
               mplier_in = dt_ff;
               cnt_in    = '0;
               state_in  = spc_pkg::S_MULI2;
            end
         end
         spc_pkg::S_MULI2: begin
            acc_in    = alu_y;
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + 1'b1;
            if (mul_is_last) begin
               state_in = spc_pkg::S_ROUND;
            end
         end
         spc_pkg::S_ROUND: begin
            acc_in   = alu_y;
            state_in = spc_pkg::S_CLAMP;
         end
         spc_pkg::S_CLAMP: begin
            held_in      = clamp_val;
            res_drive_in = clamp_val;
            res_upd_in   = 1'b1;
            state_in     = spc_pkg::S_DONE;
         end
         spc_pkg::S_DONE: begin
            // Hand over once the output register is free
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_drive_in = res_drive_ff;
               out_upd_in   = res_upd_ff;
               state_in     = spc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = spc_pkg::S_IDLE;
         end
      endcase
   end

   // Control and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spc_pkg::S_IDLE;
         out_valid_ff <= 1'b0;
         prev_err_ff  <= '0;
         err_sum_ff   <= '0;
         held_ff      <= '0;
         last_ms_ff   <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         prev_err_ff  <= prev_err_in;
         err_sum_ff   <= err_sum_in;
         held_ff      <= held_in;
         last_ms_ff   <= last_ms_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      tgt_ff       <= tgt_in;
      meas_ff      <= meas_in;
      now_ff       <= now_in;
      rst_ff       <= rst_in;
      err_ff       <= err_in;
      dt_ff        <= dt_in;
      dneg_ff      <= dneg_in;
      acc_ff       <= acc_in;
      tmp_ff       <= tmp_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      rem_ff       <= rem_in;
      res_drive_ff <= res_drive_in;
      res_upd_ff   <= res_upd_in;
      out_drive_ff <= out_drive_in;
      out_upd_ff   <= out_upd_in;
   end

endmodule

`default_nettype wire

// ===== dv/sampled_pid_controller_test.sv =====
// Self-checking testbench for the sampled PID controller: predictor, scoreboard and stimulus.
`timescale 1ns / 1ps

// One response as the block presents it
typedef struct packed {
   logic               updated;
   logic signed [15:0] drive;
} drive_result_type;

// Tracks controller state and registers, predicts each response and checks it
class pid_scoreboard;
   localparam longint ERR_SUM_MAX = 64'sd2147483647;
   localparam longint ERR_SUM_MIN = -64'sd2147483648;
   localparam int     MAX_REPORTS = 10;

   logic signed [15:0] kp, ki, kd, drive_lo, drive_hi;
   logic        [15:0] period;
   logic signed [16:0] prev_err;
   logic signed [31:0] err_sum;
   logic signed [15:0] held_drive;
   logic        [31:0] last_ms;
   drive_result_type   expected_q[$];
   int mismatches, requests, responses, updates, restarts;

   function new();
      kp = spc_pkg::RST_GAIN_P;
      ki = spc_pkg::RST_GAIN_I;
      kd = spc_pkg::RST_GAIN_D;
      drive_lo = spc_pkg::RST_OUT_MIN;
      drive_hi = spc_pkg::RST_OUT_MAX;
      period = spc_pkg::RST_SAMPLE_PERIOD;
      prev_err = '0;
      err_sum = '0;
      held_drive = '0;
      last_ms = '0;
      mismatches = 0;
      requests = 0;
      responses = 0;
      updates = 0;
      restarts = 0;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // Mirror a register write; spare indexes are dropped
   function void set_reg(logic [spc_pkg::CSR_IDX_W-1:0] index, logic [15:0] value);
      case (index)
         spc_pkg::REG_GAIN_P:        kp = value;
         spc_pkg::REG_GAIN_I:        ki = value;
         spc_pkg::REG_GAIN_D:        kd = value;
         spc_pkg::REG_OUT_MIN:       drive_lo = value;
         spc_pkg::REG_OUT_MAX:       drive_hi = value;
         spc_pkg::REG_SAMPLE_PERIOD: period = value;
         default: ;
      endcase
   endfunction

   // Advance the controller state for one accepted request and queue its response
   function void note_request(logic signed [15:0] target, logic signed [15:0] measured,
                              logic [31:0] now, logic restart);
      drive_result_type r;
      logic [31:0]      dt;
      longint           err, acc_sum, p_term, d_term, i_term, total, drive, dt_wide;
      requests++;
      dt = now - last_ms;
      dt_wide = {32'b0, dt};
      if (restart) begin
         prev_err = '0;
         err_sum = '0;
         held_drive = '0;
         last_ms = now;
         r.drive = '0;
         r.updated = 1'b0;
         restarts++;
      end else if (dt >= {16'b0, period}) begin
         err = longint'(target) - longint'(measured);
         acc_sum = longint'(err_sum) + err;
         if (acc_sum > ERR_SUM_MAX) acc_sum = ERR_SUM_MAX;
         else if (acc_sum < ERR_SUM_MIN) acc_sum = ERR_SUM_MIN;
         p_term = longint'(kp) * err;
         // no derivative when no time has passed
         d_term = 0;
         if (dt != 0) d_term = (longint'(kd) * (err - longint'(prev_err))) / dt_wide;
         // integral product wraps at 64 bits
         i_term = longint'(ki) * acc_sum * dt_wide;
         total = p_term + d_term + i_term;
         drive = total / 256;
         // with inverted limits, values below the lower limit take it and all others take the upper limit
         if (drive < longint'(drive_lo)) drive = longint'(drive_lo);
         else if (drive > longint'(drive_hi)) drive = longint'(drive_hi);
         held_drive = drive[15:0];
         prev_err = err[16:0];
         err_sum = acc_sum[31:0];
         last_ms = now;
         r.drive = drive[15:0];
         r.updated = 1'b1;
         updates++;
      end else begin
         r.drive = held_drive;
         r.updated = 1'b0;
      end
      expected_q.push_back(r);
   endfunction

   function void note_mismatch(string what, drive_result_type want, drive_result_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%s: expected drive %0d updated %0b, got drive %0d updated %0b",
                  what, $signed(want.drive), want.updated, $signed(got.drive), got.updated);
   endfunction

   // Compare a delivered response with the oldest prediction
   function void check_response(logic [15:0] drive, logic updated);
      drive_result_type want, got;
      got.drive = drive;
      got.updated = updated;
      responses++;
      if (expected_q.size() == 0) begin
         note_mismatch("response with none outstanding", '0, got);
      end else begin
         want = expected_q.pop_front();
         if (got.drive !== want.drive || got.updated !== want.updated)
            note_mismatch("response mismatch", want, got);
      end
   endfunction

   // Count predictions that never got a response
   function void flush_missing();
      while (expected_q.size() != 0)
         note_mismatch("response never arrived", expected_q.pop_front(), '0);
   endfunction
endclass

module sampled_pid_controller_test;

   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 225;
   localparam int IDLE_LIMIT      = 3000;
   localparam int END_WAIT        = 200;
   localparam logic [spc_pkg::CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [spc_pkg::CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC} ready_pattern_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [63:0] req_tdata = '0;   // [15:0] target_value, [31:16] measured_value, [63:32] now_ms
   logic req_tuser = 1'b0;        // [0] restart
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [15:0] drive_out
   logic rsp_tuser;               // [0] updated
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [spc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [spc_pkg::CSR_DAT_W-1:0] csr_wdata = '0;

   pid_scoreboard     sb;
   ready_pattern_type rx_mode = RX_OPEN;
   logic [5:0]        rx_tick = '0;
   int tx_burst_max = 1, tx_gap_max = 0, burst_left = 1;
   int idle_cycles = 0;
   int settings = 0;

   sampled_pid_controller dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Check responses and stall the response side on the current pattern
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
      rx_tick <= rx_tick + 6'd1;
      case (rx_mode)
         RX_OPEN:   rsp_tready <= 1'b1;
         RX_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
         default:   rsp_tready <= (rx_tick < 6'd40);
      endcase
   end

   // End the run when nothing moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one request, hold it until taken, then maybe idle between bursts
   task automatic send_request(logic signed [15:0] target, logic signed [15:0] measured,
                               logic [31:0] now, logic restart);
      int gap;
      req_tdata <= {now, measured, target};
      req_tuser <= restart;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(target, measured, now, restart);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, tx_burst_max);
         gap = $urandom_range(0, tx_gap_max);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drop valid and hold off until every predicted response has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Write one register; valid stays up for a following write
   task automatic write_reg(logic [spc_pkg::CSR_IDX_W-1:0] index, logic [15:0] value);
      csr_index <= index;
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(index, value);
   endtask

   task automatic program_regs(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
                               logic [15:0] lo, logic [15:0] hi, logic [15:0] per,
                               logic with_spare);
      if (with_spare) write_reg(CSR_SPARE_A, 16'($urandom));
      write_reg(spc_pkg::REG_GAIN_P, gp);
      write_reg(spc_pkg::REG_GAIN_I, gi);
      write_reg(spc_pkg::REG_GAIN_D, gd);
      write_reg(spc_pkg::REG_OUT_MIN, lo);
      write_reg(spc_pkg::REG_OUT_MAX, hi);
      write_reg(spc_pkg::REG_SAMPLE_PERIOD, per);
      if (with_spare) write_reg(CSR_SPARE_B, 16'($urandom));
      csr_valid <= 1'b0;
      settings++;
   endtask

   task automatic set_pace(int mode);
      case (mode)
         0: begin
            tx_burst_max = 1; tx_gap_max = 0; rx_mode = RX_OPEN;
         end
         1: begin
            tx_burst_max = 8; tx_gap_max = 40; rx_mode = RX_RANDOM;
         end
         default: begin
            tx_burst_max = 3; tx_gap_max = 3; rx_mode = RX_PERIODIC;
         end
      endcase
   endtask

   function automatic logic [15:0] pick_gain();
      int r;
      r = $urandom_range(0, 9);
      if (r < 2) begin
         case ($urandom_range(0, 2))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'h0000;
         endcase
      end
      if (r < 6) return 16'(int'($urandom_range(0, 1024)) - 512);
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_period();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 16'd0;
      if (r < 70) return 16'($urandom_range(1, 100));
      if (r < 90) return 16'($urandom_range(100, 3000));
      if (r < 95) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] pick_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            default: return 16'h0000;
         endcase
      end
      if (r < 5) return 16'(int'($urandom_range(0, 400)) - 200);
      return 16'($urandom);
   endfunction

   initial begin
      logic [31:0] now_ms, step, base_ms;
      logic [15:0] lo, hi, per;
      logic signed [15:0] target, measured;
      int r;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset registers: restart, hold below the period, error extremes, time wrap
      set_pace(1);
      send_request(16'sd7, 16'sd3, 32'd1000, 1'b1);
      send_request(16'sd5, 16'sd0, 32'd1000, 1'b0);
      send_request(16'sd5, 16'sd0, 32'd1074, 1'b0);
      send_request(16'h7FFF, 16'h8000, 32'd1075, 1'b0);
      send_request(16'h8000, 16'h7FFF, 32'd1150, 1'b0);
      send_request(16'sd0, 16'sd0, 32'd1225, 1'b0);
      send_request(-16'sd40, 16'sd0, 32'd1400, 1'b0);
      send_request(16'sd0, 16'sd0, 32'hFFFF_FFF0, 1'b1);
      send_request(16'sd100, 16'sd40, 32'h0000_003B, 1'b0);

      // Extreme gains and full limits, zero period: updates with no, small and wrapped elapsed time
      drain();
      program_regs(16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'd0, 1'b1);
      send_request(16'sd1234, -16'sd567, 32'h0000_003B, 1'b0);
      send_request(16'h8000, 16'h7FFF, 32'h0000_003B, 1'b0);
      send_request(16'h7FFF, 16'h8000, 32'h0000_003C, 1'b0);
      send_request(16'h7FFF, 16'sd0, 32'h0000_003B, 1'b0);

      // Opposite gain extremes, inverted limits, longest period
      drain();
      program_regs(16'h8000, 16'h7FFF, 16'h7FFF, 16'sd100, -16'sd100, 16'hFFFF, 1'b0);
      base_ms = 32'h1000_0000;
      send_request(16'sd0, 16'sd0, base_ms, 1'b1);
      send_request(16'sd50, -16'sd50, base_ms + 32'd65535, 1'b0);
      send_request(-16'sd3000, 16'sd2000, base_ms + 32'd131069, 1'b0);
      send_request(-16'sd3000, 16'sd2000, base_ms + 32'd131070, 1'b0);
      send_request(16'sd0, 16'sd0, base_ms + 32'd196605, 1'b0);
      now_ms = base_ms + 32'd196605;

      // Random phases, each with its own registers and pacing
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         if (phase == RANDOM_PHASES - 1) begin
            program_regs(spc_pkg::RST_GAIN_P, spc_pkg::RST_GAIN_I, spc_pkg::RST_GAIN_D,
                         spc_pkg::RST_OUT_MIN, spc_pkg::RST_OUT_MAX,
                         spc_pkg::RST_SAMPLE_PERIOD, 1'b0);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
               lo = 16'($urandom);
               hi = 16'($urandom);
            end else if (r < 30) begin
               lo = 16'h8000;
               hi = 16'h7FFF;
            end else begin
               lo = 16'(0 - int'($urandom_range(0, 2000)));
               hi = 16'($urandom_range(0, 2000));
            end
            per = (phase % 4 == 1) ? 16'd0 : pick_period();
            program_regs(pick_gain(), pick_gain(), pick_gain(), lo, hi, per, phase % 2 == 0);
         end
         set_pace(phase % 3);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // time steps cluster around the sample period, with jumps and wraps
            r = $urandom_range(0, 99);
            if (r < 10) step = 32'd0;
            else if (r < 30) step = $urandom_range(0, {16'b0, sb.period});
            else if (r < 42) step = {16'b0, sb.period};
            else if (r < 48) step = {16'b0, sb.period} - 32'd1;
            else if (r < 90) step = {16'b0, sb.period} + $urandom_range(1, 60);
            else step = $urandom;
            if ($urandom_range(0, 99) < 3) now_ms = $urandom;
            else now_ms = now_ms + step;
            target = pick_sample();
            measured = ($urandom_range(0, 99) < 15) ? 16'sd0 : pick_sample();
            // now and then let the pipeline run dry
            if ($urandom_range(0, 199) == 0) drain();
            send_request(target, measured, now_ms, $urandom_range(0, 99) < 4);
         end
      end

      drain();
      repeat (END_WAIT) @(posedge clock);
      sb.flush_missing();
      $display("Sent %0d requests and checked %0d responses: %0d updates, %0d restarts.",
               sb.requests, sb.responses, sb.updates, sb.restarts);
      $display("Applied %0d register settings, with extreme gains, inverted limits, zero period.",
               settings);
      if (sb.mismatches == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
